// File: rtl/npc_pkg.sv
`timescale 1ns / 1ps

package npc_pkg;

   localparam int unsigned PALETTE_DEPTH_DEFAULT = 256;

   localparam int unsigned SLOT_W  = 8;   // entry_index / best_index
   localparam int unsigned COLOR_W = 24;  // RGB888
   localparam int unsigned QUERY_W = 16;  // RGB565
   localparam int unsigned COUNT_W = 9;   // entries_in_use
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned SQ_W    = 16;
   localparam int unsigned DIST_W  = 18;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SETTLE,
      ST_LAUNCH,
      ST_SWEEP,
      ST_DELIVER
   } npc_state_type;

   // palette write broadcast to every cell
   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
      logic [COLOR_W-1:0] color;
   } npc_write_type;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
   } npc_rgb_type;

   // running best, handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [SLOT_W-1:0] idx;
      logic [DIST_W-1:0] distance;
   } npc_token_type;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// File: rtl/nearest_palette_color.sv
`timescale 1ns / 1ps

// Nearest palette color search. The palette lives in a row of PALETTE_DEPTH
// cells, one RGB888 entry per cell, written by req_action = write items
// (entry_index at or above PALETTE_DEPTH is dropped). A query item carries an
// RGB565 color; it is widened to RGB888 (c*255/31, c*255/63, truncating) and
// held where every cell sees it. Each cell keeps the squared distance from
// its entry to the query, and a token carrying the best index and distance
// walks the row one cell per clock; cells at or past csr entries_in_use pass
// it on untouched, and strict less-than keeps the lowest index on ties.
// A write item does not raise req_stall. The query is widened as it is
// accepted; after that edge req_stall stays high while PREP and SETTLE form
// the per-cell distances, LAUNCH starts the token, SWEEP carries it through
// the cell row, and DELIVER moves the result into the output register.
// The result shows on rsp_valid as req_stall drops, so the next item can be
// taken while that result is shown. If the output register still holds an
// earlier stalled result, the hand-off cycle repeats until that result leaves.
// A delivered result waits in the output register while new items are taken.
// With entries_in_use = 0 the result is found = 0 with index and distance 0.
// Entries never written read as anything; do not search them.

module nearest_palette_color #(
   parameter int unsigned PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [npc_pkg::SLOT_W-1:0]    req_entry_index,
   input  logic [npc_pkg::COLOR_W-1:0]   req_entry_color,
   input  logic [npc_pkg::QUERY_W-1:0]   req_query_color,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [npc_pkg::SLOT_W-1:0]    rsp_best_index,
   output logic [npc_pkg::DIST_W-1:0]    rsp_best_distance,
   output logic                          rsp_found,

   input  logic                          csr_wr_en,
   input  logic [npc_pkg::COUNT_W-1:0]   csr_wr_data
);

   // 5-bit channel to 8 bits: 8c + floor(7c/31), steps at 5,9,14,18,23,27,31
   function automatic logic [7:0] widen5(input logic [4:0] c);
      logic [7:0] w;
      w = {c, 3'b000}
          + {7'd0, c >= 5'd5}  + {7'd0, c >= 5'd9}  + {7'd0, c >= 5'd14}
          + {7'd0, c >= 5'd18} + {7'd0, c >= 5'd23} + {7'd0, c >= 5'd27}
          + {7'd0, c >= 5'd31};
      return w;
   endfunction

   // 6-bit channel to 8 bits: 4c + floor(c/21)
   function automatic logic [7:0] widen6(input logic [5:0] c);
      logic [7:0] w;
      w = {c, 2'b00}
          + {7'd0, c >= 6'd21} + {7'd0, c >= 6'd42} + {7'd0, c >= 6'd63};
      return w;
   endfunction

   npc_pkg::npc_state_type        state_ff, state_in;
   logic [npc_pkg::COUNT_W-1:0]   count_ff, count_in;
   npc_pkg::npc_rgb_type          query_ff, query_in;
   npc_pkg::npc_token_type        result_ff, result_in;
   npc_pkg::npc_write_type        wr_bus;
   npc_pkg::npc_token_type        chain [0:PALETTE_DEPTH];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [npc_pkg::SLOT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [npc_pkg::DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                          rsp_found_ff, rsp_found_in;

   logic req_take, query_take, launch, capture, load_out;

   assign req_take   = req_valid && !req_stall;
   assign query_take = req_take && (req_action == npc_pkg::ACTION_QUERY);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npc_pkg::ST_IDLE: begin
            if (query_take) begin
               state_in = npc_pkg::ST_PREP;
            end
         end
         npc_pkg::ST_PREP:   state_in = npc_pkg::ST_SETTLE;
         npc_pkg::ST_SETTLE: state_in = npc_pkg::ST_LAUNCH;
         npc_pkg::ST_LAUNCH: state_in = npc_pkg::ST_SWEEP;
         npc_pkg::ST_SWEEP: begin
            if (chain[PALETTE_DEPTH].valid) begin
               state_in = npc_pkg::ST_DELIVER;
            end
         end
         npc_pkg::ST_DELIVER: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = npc_pkg::ST_IDLE;
            end
         end
         default: state_in = npc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      launch    = 1'b0;
      capture   = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         npc_pkg::ST_IDLE:    req_stall = 1'b0;
         npc_pkg::ST_PREP:    req_stall = 1'b1;
         npc_pkg::ST_SETTLE:  req_stall = 1'b1;
         npc_pkg::ST_LAUNCH:  launch    = 1'b1;
         npc_pkg::ST_SWEEP:   capture   = chain[PALETTE_DEPTH].valid;
         npc_pkg::ST_DELIVER: load_out  = !rsp_valid_ff || !rsp_stall;
         default:             req_stall = 1'b1;
      endcase
   end

   // ---------------- datapath ----------------
   // empty token enters cell 0
   assign chain[0] = '{valid: launch, found: 1'b0, idx: '0, distance: '0};

   always_comb begin
      count_in = csr_wr_en ? csr_wr_data : count_ff;

      query_in = query_ff;
      if (query_take) begin
         query_in.r = widen5(req_query_color[15:11]);
         query_in.g = widen6(req_query_color[10:5]);
         query_in.b = widen5(req_query_color[4:0]);
      end

      wr_bus.en    = req_take && (req_action == npc_pkg::ACTION_WRITE);
      wr_bus.slot  = req_entry_index;
      wr_bus.color = req_entry_color;

      result_in = capture ? chain[PALETTE_DEPTH] : result_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_found_in = rsp_found_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = result_ff.idx;
         rsp_dist_in  = result_ff.distance;
         rsp_found_in = result_ff.found;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
         npc_cell #(
            .INDEX (gi)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .wr      (wr_bus),
            .query   (query_ff),
            .entries (count_ff),
            .tok_in  (chain[gi]),
            .tok_out (chain[gi+1])
         );
      end
   endgenerate

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      result_ff    <= result_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_found         = rsp_found_ff;

endmodule

// File: rtl/npc_cell.sv
`timescale 1ns / 1ps

module npc_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  npc_pkg::npc_write_type        wr,
   input  npc_pkg::npc_rgb_type          query,
   input  logic [npc_pkg::COUNT_W-1:0]   entries,
   input  npc_pkg::npc_token_type        tok_in,
   output npc_pkg::npc_token_type        tok_out
);

   localparam bit WRITABLE  = INDEX < (1 << npc_pkg::SLOT_W);
   localparam bit COUNTABLE = INDEX < (1 << npc_pkg::COUNT_W);
   localparam logic [npc_pkg::SLOT_W-1:0]  SLOT = INDEX[npc_pkg::SLOT_W-1:0];
   localparam logic [npc_pkg::COUNT_W-1:0] POS  = INDEX[npc_pkg::COUNT_W-1:0];

   logic [npc_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [npc_pkg::SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npc_pkg::SQ_W-1:0]    sq_r_in, sq_g_in, sq_b_in;
   logic [npc_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [npc_pkg::CHAN_W-1:0]  dr, dg, db;
   logic                        active, take;
   logic                        tok_valid_ff, tok_valid_in;
   logic                        tok_found_ff, tok_found_in;
   logic [npc_pkg::SLOT_W-1:0]  tok_idx_ff, tok_idx_in;
   logic [npc_pkg::DIST_W-1:0]  tok_dist_ff, tok_dist_in;

   always_comb begin
      color_in = color_ff;
      if (wr.en && WRITABLE && (wr.slot == SLOT)) begin
         color_in = wr.color;
      end
   end

   // distance to the held query, two register stages
   always_comb begin
      dr      = npc_pkg::abs_diff(query.r, color_ff[23:16]);
      dg      = npc_pkg::abs_diff(query.g, color_ff[15:8]);
      db      = npc_pkg::abs_diff(query.b, color_ff[7:0]);
      sq_r_in = {8'd0, dr} * {8'd0, dr};
      sq_g_in = {8'd0, dg} * {8'd0, dg};
      sq_b_in = {8'd0, db} * {8'd0, db};
      dist_in = {2'b00, sq_r_ff} + {2'b00, sq_g_ff} + {2'b00, sq_b_ff};
   end

   always_comb begin
      active       = COUNTABLE && (POS < entries);
      take         = active && (!tok_in.found || (dist_ff < tok_in.distance));
      tok_valid_in = tok_in.valid;
      tok_found_in = tok_in.found | active;
      tok_idx_in   = take ? SLOT    : tok_in.idx;
      tok_dist_in  = take ? dist_ff : tok_in.distance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff    <= color_in;
      sq_r_ff     <= sq_r_in;
      sq_g_ff     <= sq_g_in;
      sq_b_ff     <= sq_b_in;
      dist_ff     <= dist_in;
      tok_found_ff <= tok_found_in;
      tok_idx_ff  <= tok_idx_in;
      tok_dist_ff <= tok_dist_in;
   end

   assign tok_out = '{valid: tok_valid_ff, found: tok_found_ff,
                      idx: tok_idx_ff, distance: tok_dist_ff};

endmodule

// File: rtl/npc_checker.sv
`timescale 1ns / 1ps

module npc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_action,
   input logic [npc_pkg::SLOT_W-1:0]    req_entry_index,
   input logic [npc_pkg::COLOR_W-1:0]   req_entry_color,
   input logic [npc_pkg::QUERY_W-1:0]   req_query_color,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [npc_pkg::SLOT_W-1:0]    rsp_best_index,
   input logic [npc_pkg::DIST_W-1:0]    rsp_best_distance,
   input logic                          rsp_found,
   input logic                          csr_wr_en,
   input logic [npc_pkg::COUNT_W-1:0]   csr_wr_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_index)
         && $stable(rsp_best_distance) && $stable(rsp_found))
      else $error("result changed while stalled");

   // empty search reports zeros
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_best_index == '0) && (rsp_best_distance == '0))
      else $error("not-found result carries nonzero fields");

   // a query occupies the search row
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == npc_pkg::ACTION_QUERY) |=> req_stall)
      else $error("input taken right after a query");

   // a new result only comes out of a search in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a search");

endmodule

bind nearest_palette_color npc_checker u_npc_checker (.*);
